// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// clocked next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== design/sha256_pkg.sv =====
// Package: constants, types and round functions of the SHA-256 lane block
package sha256_pkg;
    localparam int LANE_COUNT  = 16;
    localparam int ROUND_COUNT = 64;
    localparam int LANE_W      = 4;
    localparam int LANE_SEL_W  = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int ROUND_W     = 7;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_MSG   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOADW, ST_LOADH, ST_ROUND, ST_ADD, ST_READ
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       msg_wr;     // store message word
        logic       chain_wr;   // store chaining word from input
        logic       rd_req;     // issue chaining read at input address
        logic       load_w;     // read message word count_reg, shift previous word into schedule
        logic       load_h;     // load chaining word into working vars
        logic       round_en;   // run one round
        logic       add_wr;     // add working var back into chaining word
        logic       out_en;     // present read data
        logic [6:0] count;      // step counter
    } ctrl_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    localparam word_t K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
endpackage

// ===== design/sha256_ctrl.sv =====
// Controller: sequences stores, reads, schedule load, rounds and write-back
module sha256_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             command,
    input  logic [3:0]             lane,
    input  logic [3:0]             word_index,
    output logic                   busy,
    output sha256_pkg::ctrl_t      ctrl
);
    import sha256_pkg::*;

    state_t     state_reg, state_next;
    logic [6:0] count_reg, count_next;
    logic       lane_ok;
    logic       go;

    assign lane_ok = ({28'd0, lane} < LANE_COUNT);
    assign go      = start && !busy && lane_ok;

    // state and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ctrl          = '0;
        ctrl.count    = count_reg;
        busy          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    case (command)
                        CMD_WRITE: ctrl.chain_wr = 1'b1;
                        CMD_MSG:
                        begin
                            ctrl.msg_wr = 1'b1;
                            if (word_index == 4'd15)
                            begin
                                state_next = ST_LOADW;
                                count_next = '0;
                            end
                        end
                        CMD_READ:
                        begin
                            ctrl.rd_req = 1'b1;
                            state_next  = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                ctrl.out_en = 1'b1;
                state_next  = ST_IDLE;
            end
            // one message word per cycle, read data lands next cycle
            ST_LOADW:
            begin
                ctrl.load_w = 1'b1;
                if (count_reg == 7'd16)
                begin
                    state_next = ST_LOADH;
                    count_next = '0;
                end
                else
                    count_next = count_reg + 7'd1;
            end
            ST_LOADH:
            begin
                ctrl.load_h = 1'b1;
                if (count_reg == 7'd8)
                begin
                    state_next = ST_ROUND;
                    count_next = '0;
                end
                else
                    count_next = count_reg + 7'd1;
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                if (count_reg == 7'(ROUND_COUNT - 1))
                begin
                    state_next = ST_ADD;
                    count_next = '0;
                end
                else
                    count_next = count_reg + 7'd1;
            end
            // read chaining word, add, write back: each write uses the word read in the cycle before
            ST_ADD:
            begin
                ctrl.add_wr = 1'b1;
                if (count_reg == 7'd8)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                end
                else
                    count_next = count_reg + 7'd1;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== design/sha256_datapath.sv =====
// Datapath: lane memories, message schedule, working variables and round logic
module sha256_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::ctrl_t      ctrl,
    input  logic [3:0]             lane,
    input  logic [3:0]             word_index,
    input  logic [31:0]            data_word,
    output logic                   done,
    output logic [31:0]            digest_word,
    output logic [3:0]             out_lane,
    output logic [2:0]             out_index
);
    import sha256_pkg::*;

    localparam int CW_DEPTH = LANE_COUNT * 8;
    localparam int MB_DEPTH = LANE_COUNT * 16;
    localparam int CW_AW    = LANE_SEL_W + 3;
    localparam int MB_AW    = LANE_SEL_W + 4;

    word_t chain_mem [CW_DEPTH];
    word_t msg_mem   [MB_DEPTH];
    word_t chain_rd_reg;
    word_t msg_rd_reg;

    word_t w_reg [16];
    word_t v_reg [8];
    logic [LANE_SEL_W-1:0] lane_reg;
    logic [2:0]            idx_reg;

    logic [LANE_SEL_W-1:0] lane_sel;
    logic [CW_AW-1:0]      cw_raddr, cw_waddr;
    logic [MB_AW-1:0]      mb_raddr;
    logic [2:0]            cnt3, cnt3_prev;
    word_t                 s0, s1, wt, t1, t2, wnew;
    logic [5:0]            rnd;

    assign lane_sel  = lane[LANE_SEL_W-1:0];
    assign cnt3      = ctrl.count[2:0];
    assign cnt3_prev = 3'(ctrl.count - 7'd1);
    assign rnd       = ctrl.count[5:0];

    // chaining addresses: input address when idle, else sequenced; message read address always sequenced
    always_comb
    begin
        if (ctrl.load_h || ctrl.add_wr)
            cw_raddr = {lane_reg, cnt3};
        else
            cw_raddr = {lane_sel, word_index[2:0]};
        if (ctrl.add_wr)
            cw_waddr = {lane_reg, cnt3_prev};
        else
            cw_waddr = {lane_sel, word_index[2:0]};
        mb_raddr = {lane_reg, ctrl.count[3:0]};
    end

    // lane memories
    always_ff @(posedge clk)
    begin
        if (ctrl.msg_wr)
            msg_mem[{lane_sel, word_index}] <= data_word;
        msg_rd_reg <= msg_mem[mb_raddr];
        if (ctrl.chain_wr)
            chain_mem[cw_waddr] <= data_word;
        else if (ctrl.add_wr && ctrl.count != 7'd0)
            chain_mem[cw_waddr] <= chain_rd_reg + v_reg[cnt3_prev];
        chain_rd_reg <= chain_mem[cw_raddr];
    end

    // schedule and round functions; schedule word is w_reg[0] below round 16, computed from the window after
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + s1 + w_reg[9];
        wt = (rnd >= 6'd16) ? wnew : w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + K[rnd] + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // lane capture, loads and window shift: for rounds below 16 the window just rotates
    always_ff @(posedge clk)
    begin
        if (ctrl.msg_wr)
            lane_reg <= lane_sel;
        if (ctrl.rd_req)
        begin
            lane_reg <= lane_sel;
            idx_reg  <= word_index[2:0];
        end
        if (ctrl.load_w && ctrl.count != 7'd0)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= msg_rd_reg;
        end
        if (ctrl.load_h && ctrl.count != 7'd0)
            v_reg[cnt3_prev] <= chain_rd_reg;
        if (ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= ctrl.out_en;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            digest_word <= chain_rd_reg;
            out_lane    <= LANE_W'(lane_reg);
            out_index   <= idx_reg;
        end
    end
endmodule

// ===== design/sha256_multilane_compress.sv =====
// Top level: multi-lane SHA-256 compression block
// Usage: drive command, lane, word_index and data_word with start; a word is
// taken at a clock edge where start is high and busy is low.
// Write chaining word and message words 0..14 are stored without raising busy.
// Message word 15 starts a compression of that lane: the schedule is loaded
// from the lane's message memory, then the chaining words are loaded, 64
// rounds run at one per cycle and the result is added back into the
// chaining words, with busy high throughout.
// A read holds busy for one cycle and drives its word with done high in the
// cycle after that busy cycle, for exactly one cycle; the receiver cannot
// hold it off.
// Lanes at or above the lane count and command three are ignored.
// Reset clears the controller; the lane memories hold nothing defined
// until written.
module sha256_multilane_compress (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  lane,
    input  logic [3:0]  word_index,
    input  logic [31:0] data_word,
    output logic        done,
    output logic [31:0] digest_word,
    output logic [3:0]  out_lane,
    output logic [2:0]  out_index
);
    import sha256_pkg::*;

    ctrl_t ctrl;

    sha256_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command), .lane(lane),
        .word_index(word_index), .busy(busy), .ctrl(ctrl)
    );

    sha256_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .lane(lane), .word_index(word_index),
        .data_word(data_word), .done(done), .digest_word(digest_word),
        .out_lane(out_lane), .out_index(out_index)
    );
endmodule

// ===== design/sha256_checker.sv =====
// Port checker for the SHA-256 lane block, bound to the top level
`include "assert_macros.svh"
module sha256_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic [3:0] word_index,
    input logic       done
);
    import sha256_pkg::*;

    `ASSERT_NEXT(a_read_busy, clk, rst_n, start && !busy && command == CMD_READ, busy)
    `ASSERT_NEXT(a_read_done, clk, rst_n, start && !busy && command == CMD_READ, ##1 done)
    `ASSERT_IMPL(a_done_single, clk, rst_n, done, !$past(done))
    `ASSERT_NEXT(a_compress_busy, clk, rst_n,
                 start && !busy && command == CMD_MSG && word_index == 4'd15, busy)
endmodule

bind sha256_multilane_compress sha256_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
    .word_index(word_index), .done(done)
);
